// File: src/mctw_pkg.sv
// package for the multi-channel task watchdog
// holds command codes and the structs passed between top level and channel cells
// no dependencies
`timescale 1ns / 1ps

package mctw_pkg;

    // command code carried in the func field
    typedef logic [2:0] func_t;

    localparam func_t FN_TICK     = 3'd0;
    localparam func_t FN_REGISTER = 3'd1;
    localparam func_t FN_KICK     = 3'd2;
    localparam func_t FN_START    = 3'd3;
    localparam func_t FN_STOP     = 3'd4;

    // width of the result masks
    localparam int MASK_W = 8;

    // decoded command for one channel cell, only set in the cycle it is applied
    typedef struct packed {
        logic tick;
        logic do_register;
        logic do_kick;
        logic do_start;
        logic do_stop;
        logic own_handler;
    } chan_cmd_t;

    // channel status back to the top level
    typedef struct packed {
        logic expired;
        logic custom;
    } chan_stat_t;

endpackage

// File: src/mctw_chan.sv
// one watchdog channel: enable, counter, limit and handler choice
// depends on mctw_pkg
`timescale 1ns / 1ps

module mctw_chan #(
    parameter int LIMIT_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mctw_pkg::chan_cmd_t      cmd,
    input  logic [LIMIT_BITS-1:0]    new_limit,
    output mctw_pkg::chan_stat_t     stat
);
    import mctw_pkg::*;

    localparam int COUNT_W = LIMIT_BITS + 1;

    logic                  enabled_reg;
    logic                  enabled_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic [LIMIT_BITS-1:0] limit_reg;
    logic [LIMIT_BITS-1:0] limit_next;
    logic                  custom_reg;
    logic                  custom_next;
    logic                  armed;
    logic                  expired;

    // channel is timing and has passed its limit
    assign armed   = enabled_reg && (limit_reg != '0);
    assign expired = armed && (count_reg > {1'b0, limit_reg});

    assign stat.expired = expired;
    assign stat.custom  = custom_reg;

    // command effects on the channel state
    always_comb
    begin
        enabled_next = enabled_reg;
        count_next   = count_reg;
        limit_next   = limit_reg;
        custom_next  = custom_reg;
        if (cmd.tick)
        begin
            if (armed && !expired)
            begin
                count_next = COUNT_W'(count_reg + 1'b1);
            end
        end
        if (cmd.do_register)
        begin
            enabled_next = 1'b0;
            count_next   = '0;
            limit_next   = new_limit;
            custom_next  = cmd.own_handler;
        end
        if (cmd.do_kick)
        begin
            count_next = '0;
        end
        if (cmd.do_start && !enabled_reg)
        begin
            enabled_next = 1'b1;
            count_next   = '0;
        end
        if (cmd.do_stop && enabled_reg)
        begin
            enabled_next = 1'b0;
            count_next   = '0;
        end
    end

    // channel state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            count_reg   <= '0;
            limit_reg   <= '0;
            custom_reg  <= 1'b0;
        end
        else
        begin
            enabled_reg <= enabled_next;
            count_reg   <= count_next;
            limit_reg   <= limit_next;
            custom_reg  <= custom_next;
        end
    end

endmodule

// File: src/multi_channel_task_watchdog.sv
// top level of the multi-channel task watchdog: input register, command decode,
// channel cells and result register; depends on mctw_pkg and mctw_chan
//
// channel  | signals                                  | role
// ---------+------------------------------------------+---------------------------
// in       | in_valid, in_stall, func, channel,       | one command or tick per beat
//          | limit, own_handler                       |
// out      | out_valid, out_stall, timeout_mask,      | one result per command beat
//          | handler_mask, reset_request              |
// cfg      | cfg_write, cfg_data                      | guard_enable register write
//
// one beat per cycle sustained while out_stall is low; a beat passes the input register
// and the result register around the single decode and channel update pass
// reset clears all channels to disabled with zero count and limit; guard_enable
// comes out of reset set
// a stalled result holds the result register; the input register still takes one
// more beat, then in_stall rises until the result drains
`timescale 1ns / 1ps

module multi_channel_task_watchdog #(
    parameter int CHANNELS   = 8,
    parameter int LIMIT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [2:0]  channel,
    input  logic [15:0] limit,
    input  logic        own_handler,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  timeout_mask,
    output logic [7:0]  handler_mask,
    output logic        reset_request
);
    import mctw_pkg::*;

    localparam int PAD_W = (CHANNELS > MASK_W) ? CHANNELS : MASK_W;

    logic                  guard_reg;
    logic                  guard_next;
    logic                  in_valid_reg;
    logic                  in_valid_next;
    func_t                 func_reg;
    logic [2:0]            channel_reg;
    logic [15:0]           limit_reg;
    logic                  own_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [MASK_W-1:0]     tmask_reg;
    logic [MASK_W-1:0]     tmask_next;
    logic [MASK_W-1:0]     hmask_reg;
    logic [MASK_W-1:0]     hmask_next;
    logic                  rreq_reg;
    logic                  rreq_next;
    logic                  accept;
    logic                  advance;
    logic                  is_tick;
    logic                  is_register;
    logic                  is_kick;
    logic                  is_start;
    logic                  is_stop;
    logic [LIMIT_BITS-1:0] chan_limit;
    logic [CHANNELS-1:0]   exp_vec;
    logic [CHANNELS-1:0]   cust_vec;
    logic [PAD_W-1:0]      exp_pad;
    logic [PAD_W-1:0]      hnd_pad;
    chan_cmd_t             cmd [CHANNELS];
    chan_stat_t            stat [CHANNELS];

    // handshake: input register refills as soon as its beat moves on
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign advance  = in_valid_reg && !(out_valid_reg && out_stall);

    // guard register
    assign guard_next = cfg_write ? cfg_data : guard_reg;

    // command decode of the held beat
    always_comb
    begin
        is_tick     = 1'b0;
        is_register = 1'b0;
        is_kick     = 1'b0;
        is_start    = 1'b0;
        is_stop     = 1'b0;
        unique case (func_reg)
            FN_TICK:     is_tick     = advance;
            FN_REGISTER: is_register = advance;
            FN_KICK:     is_kick     = advance;
            FN_START:    is_start    = advance && guard_reg;
            FN_STOP:     is_stop     = advance;
            default:     ;
        endcase
    end

    assign chan_limit = LIMIT_BITS'(limit_reg);

    // channel cells
    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_chan
        logic hit;

        assign hit = (32'(channel_reg) == 32'(i));

        always_comb
        begin
            cmd[i].tick        = is_tick;
            cmd[i].do_register = is_register && hit;
            cmd[i].do_kick     = is_kick && hit;
            cmd[i].do_start    = is_start && hit;
            cmd[i].do_stop     = is_stop && hit;
            cmd[i].own_handler = own_reg;
        end

        mctw_chan #(
            .LIMIT_BITS (LIMIT_BITS)
        ) u_chan (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd[i]),
            .new_limit (chan_limit),
            .stat      (stat[i])
        );

        assign exp_vec[i]  = stat[i].expired;
        assign cust_vec[i] = stat[i].custom;
    end

    // result of the held beat, zero unless it is a tick
    assign exp_pad = PAD_W'(exp_vec);
    assign hnd_pad = PAD_W'(exp_vec & cust_vec);

    always_comb
    begin
        tmask_next = '0;
        hmask_next = '0;
        rreq_next  = 1'b0;
        if (is_tick)
        begin
            tmask_next = exp_pad[MASK_W-1:0];
            hmask_next = hnd_pad[MASK_W-1:0];
            rreq_next  = guard_reg && ((exp_vec & ~cust_vec) != '0);
        end
    end

    // valid bits of both stages
    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            guard_reg     <= 1'b1;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            guard_reg     <= guard_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= func;
            channel_reg <= channel;
            limit_reg   <= limit;
            own_reg     <= own_handler;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tmask_reg <= tmask_next;
            hmask_reg <= hmask_next;
            rreq_reg  <= rreq_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign timeout_mask  = tmask_reg;
    assign handler_mask  = hmask_reg;
    assign reset_request = rreq_reg;

endmodule
